>>> src/tdt_pkg.sv
// Shared types and command codes for the table-driven transducer.
package tdt_pkg;

  localparam int BYTE_W = 8;
  localparam int COLS   = 256;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // One transition table entry: final mark, output byte, next state.
  typedef struct packed {
    logic              final_mark;
    logic [BYTE_W-1:0] out;
    logic [BYTE_W-1:0] next;
  } entry_t;

  // Access request from the control logic to the table memory.
  typedef struct packed {
    logic we;
    logic re;
  } tbl_req_t;

endpackage

>>> src/tdt_table.sv
// Transition table memory: one port, registered synchronous read.
module tdt_table #(
  parameter int ADDR_W = 16
) (
  input  logic                clk,
  input  tdt_pkg::tbl_req_t   req,
  input  logic [ADDR_W-1:0]   addr,
  input  tdt_pkg::entry_t     wdata,
  output tdt_pkg::entry_t     rdata
);
  import tdt_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= wdata;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/table_driven_transducer.sv
// Table-driven transducer: a byte stream walks a loaded transition table, one entry per state and
// byte, emitting output bytes and an end-of-string result with the final state and its acceptance.
// The block takes one item per clock cycle when the result side does not stall. The figure is set
// by the state loop through the table memory: the registered read data of one lookup gives the next
// state, which forms the address of the following lookup in the same cycle. A result passes the
// table read register and then the output register. The table holds min(NUM_STATES, 256) rows
// of 256 entries of 17 bits and is not cleared: every entry must be written before it is read. Rows
// at or beyond NUM_STATES ignore writes and read as an all-zero entry.
module table_driven_transducer #(
  parameter int NUM_STATES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] entry_state,
  input  logic [7:0] entry_byte,
  input  logic [7:0] entry_next,
  input  logic [7:0] entry_out,
  input  logic       entry_final,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [7:0] matched_state,
  output logic       is_end,
  output logic       accepted
);
  import tdt_pkg::*;

  localparam int ROWS   = (NUM_STATES > COLS) ? COLS : NUM_STATES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + BYTE_W;
  localparam logic [BYTE_W:0] ROW_LIM = (BYTE_W + 1)'(ROWS);

  logic [BYTE_W-1:0] state;
  logic              s1_valid;
  logic              s1_is_end;
  logic              s1_row_ok;
  logic [BYTE_W-1:0] s1_cur;

  entry_t            rdata;
  entry_t            wdata;
  entry_t            s1_entry;
  tbl_req_t          req;
  logic [ADDR_W-1:0] addr;

  logic              accept;
  logic              s1_emit;
  logic              s1_advance;
  logic [BYTE_W-1:0] s1_state_next;
  logic [BYTE_W-1:0] eff_state;
  logic [BYTE_W-1:0] read_col;
  logic              wrow_ok;
  logic              rrow_ok;
  logic              is_write;
  logic              is_read;
  logic              is_end_cmd;

  // An entry from a row past the table reads as zero.
  assign s1_entry = s1_row_ok ? rdata : '0;

  always_comb begin
    if (s1_is_end) begin
      s1_emit       = 1'b1;
      s1_state_next = '0;
    end else begin
      s1_emit       = (s1_entry.out != '0);
      s1_state_next = s1_entry.next;
    end
  end

  assign s1_advance = s1_valid && (!s1_emit || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_advance;
  assign accept     = item_valid && !item_stall;

  // Forward the state of the item in flight to the next lookup.
  assign eff_state = s1_valid ? s1_state_next : state;

  always_comb begin
    is_write   = 1'b0;
    is_read    = 1'b0;
    is_end_cmd = 1'b0;
    unique case (cmd)
      CMD_WRITE: is_write = 1'b1;
      CMD_BYTE:  is_read  = 1'b1;
      CMD_END: begin
        is_read    = 1'b1;
        is_end_cmd = 1'b1;
      end
      default: ;
    endcase
  end

  assign wrow_ok  = {1'b0, entry_state} < ROW_LIM;
  assign rrow_ok  = {1'b0, eff_state} < ROW_LIM;
  assign read_col = is_end_cmd ? '0 : data_byte;

  assign req.we = accept && is_write && wrow_ok;
  assign req.re = accept && is_read;
  assign addr   = is_write ? {entry_state[ROW_W-1:0], entry_byte}
                           : {eff_state[ROW_W-1:0], read_col};

  assign wdata.final_mark = entry_final;
  assign wdata.out        = entry_out;
  assign wdata.next       = entry_next;

  tdt_table #(
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk  (clk),
    .req  (req),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_valid && s1_advance) begin
        state <= s1_state_next;
      end
      if (!s1_valid || s1_advance) begin
        s1_valid <= accept && is_read;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      s1_is_end <= is_end_cmd;
      s1_row_ok <= rrow_ok;
      s1_cur    <= eff_state;
    end
  end

  // Output register: load a finished result, drop it once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_valid && s1_advance && s1_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance && s1_emit) begin
      is_end <= s1_is_end;
      if (s1_is_end) begin
        out_byte      <= '0;
        matched_state <= s1_cur;
        accepted      <= s1_entry.final_mark;
      end else begin
        out_byte      <= s1_entry.out;
        matched_state <= s1_entry.next;
        accepted      <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a pending result");

  a_end_resets_state: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance && s1_is_end |=> state == '0)
    else $error("state not returned to zero after end of string");

  a_end_result_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_end |-> out_byte == '0)
    else $error("end result carries an output byte");

  a_byte_result_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_end |-> out_byte != '0 && !accepted)
    else $error("byte result with zero output or acceptance set");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the table-driven transducer: random table loads and byte strings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdt_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned QUIET_AFTER = 570;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] state;
    logic       is_end;
    logic       accepted;
  } tdt_result_t;

  class transducer_scoreboard;
    entry_t      trans_table[65536];
    bit          loaded[65536];
    logic [7:0]  cur_state;
    tdt_result_t pending_results[$];
    int          n_errors;

    function new();
      cur_state = '0;
      n_errors  = 0;
    endfunction

    function void report(string what);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Walk the table for one accepted transfer and queue the result it causes.
    function void note_item(logic [1:0] c, logic [7:0] es, logic [7:0] eb, logic [7:0] en,
                            logic [7:0] eo, logic ef, logic [7:0] db);
      entry_t      ent;
      tdt_result_t res;
      case (c)
        CMD_WRITE: begin
          trans_table[{es, eb}] = '{final_mark: ef, out: eo, next: en};
          loaded[{es, eb}]      = 1'b1;
        end
        CMD_BYTE: begin
          ent       = trans_table[{cur_state, db}];
          cur_state = ent.next;
          if (ent.out != 8'd0) begin
            res = '{out_byte: ent.out, state: cur_state, is_end: 1'b0, accepted: 1'b0};
            pending_results.push_back(res);
          end
        end
        CMD_END: begin
          ent = trans_table[{cur_state, 8'd0}];
          res = '{out_byte: 8'd0, state: cur_state, is_end: 1'b1, accepted: ent.final_mark};
          pending_results.push_back(res);
          cur_state = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] ob, logic [7:0] st, logic e, logic acc);
      tdt_result_t exp_r;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result out_byte=%0h state=%0h is_end=%b accepted=%b",
                         ob, st, e, acc));
        return;
      end
      exp_r = pending_results.pop_front();
      if (ob !== exp_r.out_byte)
        report($sformatf("out_byte %0h, expected %0h", ob, exp_r.out_byte));
      if (st !== exp_r.state)
        report($sformatf("matched_state %0h, expected %0h", st, exp_r.state));
      if (e !== exp_r.is_end)
        report($sformatf("is_end %b, expected %b", e, exp_r.is_end));
      if (acc !== exp_r.accepted)
        report($sformatf("accepted %b, expected %b", acc, exp_r.accepted));
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic [1:0] cmd          = CMD_WRITE;
  logic [7:0] entry_state  = '0;
  logic [7:0] entry_byte   = '0;
  logic [7:0] entry_next   = '0;
  logic [7:0] entry_out    = '0;
  logic       entry_final  = 1'b0;
  logic [7:0] data_byte    = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic [7:0] matched_state;
  logic       is_end;
  logic       accepted;

  transducer_scoreboard sb = new();
  int unsigned n_items = 0;
  bit          quiet   = 1'b0;
  logic [7:0]  state_pool[8];

  table_driven_transducer u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .entry_state   (entry_state),
    .entry_byte    (entry_byte),
    .entry_next    (entry_next),
    .entry_out     (entry_out),
    .entry_final   (entry_final),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .matched_state (matched_state),
    .is_end        (is_end),
    .accepted      (accepted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one item, hold it until the transfer, then log it with the scoreboard.
  task automatic drive_item(input logic [1:0] c, input logic [7:0] es, input logic [7:0] eb,
                            input logic [7:0] en, input logic [7:0] eo, input logic ef,
                            input logic [7:0] db);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    cmd         <= c;
    entry_state <= es;
    entry_byte  <= eb;
    entry_next  <= en;
    entry_out   <= eo;
    entry_final <= ef;
    data_byte   <= db;
    // Inputs only move at the rising edge, so the falling-edge view is settled.
    do @(negedge clk); while (item_stall !== 1'b0);
    @(posedge clk);
    sb.note_item(c, es, eb, en, eo, ef, db);
    if (c != CMD_UNUSED)
      n_items++;
    quiet = (n_items >= QUIET_AFTER);
  endtask

  task automatic send_write(input logic [7:0] s, input logic [7:0] b, input logic [7:0] nx,
                            input logic [7:0] o, input logic f);
    drive_item(CMD_WRITE, s, b, nx, o, f, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_item(CMD_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom), b);
  endtask

  task automatic send_end();
    drive_item(CMD_END, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    drive_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom), 8'($urandom));
  endtask

  // Load the entry about to be read with random content; the next state mostly stays in the pool.
  task automatic load_entry(input logic [7:0] s, input logic [7:0] b);
    logic [7:0] nx;
    logic [7:0] o;
    nx = ($urandom_range(0, 4) != 0) ? state_pool[3'($urandom_range(0, 7))] : 8'($urandom);
    o  = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(1, 255));
    send_write(s, b, nx, o, 1'($urandom));
  endtask

  task automatic run_string();
    int unsigned len;
    logic [7:0]  b;
    len = $urandom_range(1, 10);
    for (int unsigned k = 0; k < len; k++) begin
      b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      // Break the sequence now and then: overwrite the path or slip in an unused command.
      if ($urandom_range(0, 9) == 0)
        load_entry(sb.cur_state, b);
      else if ($urandom_range(0, 29) == 0)
        send_noise();
      if (!sb.loaded[{sb.cur_state, b}])
        load_entry(sb.cur_state, b);
      send_byte(b);
    end
    if ($urandom_range(0, 6) != 0) begin
      if (!sb.loaded[{sb.cur_state, 8'd0}])
        load_entry(sb.cur_state, 8'd0);
      send_end();
    end
  endtask

  initial begin
    int unsigned r;
    foreach (state_pool[i])
      state_pool[i] = 8'($urandom);
    state_pool[0] = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_write(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
    send_write(8'd255, 8'd255, 8'd0, 8'd1, 1'b0);
    send_write(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
    send_write(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd255);   // zero output: state stays at zero, nothing emitted
    send_byte(8'd0);
    send_byte(8'd0);
    send_end();          // accepting end from the top state
    send_end();          // end right after end, from state zero
    send_noise();
    send_write(8'd0, 8'd0, 8'h5a, 8'h80, 1'b0);
    send_write(8'h5a, 8'd0, 8'd0, 8'h7f, 1'b1);
    send_byte(8'd0);
    send_write(8'h5a, 8'h5a, 8'ha5, 8'h01, 1'b0);   // write in the middle of a string
    send_write(8'ha5, 8'd0, 8'h5a, 8'h00, 1'b0);
    send_byte(8'h5a);
    send_byte(8'd0);
    send_end();
    send_end();          // rejecting end: final mark of entry zero is clear
    send_noise();

    while (n_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        send_noise();
      else if (r < 12)
        send_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        run_string();
    end
    item_valid <= 1'b0;

    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Result side stall: random bursts between stall-free runs, none once the run winds down.
  initial begin
    int unsigned run;
    int unsigned burst;
    wait (!rst);
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 30);
      repeat (run) @(posedge clk) result_stall <= 1'b0;
      burst = $urandom_range(1, 14);
      for (int j = 0; j < burst && !quiet; j++)
        @(posedge clk) result_stall <= 1'b1;
      @(posedge clk) result_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_result(out_byte, matched_state, is_end, accepted);
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(negedge clk);
      if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/tdt_pkg.sv
src/tdt_table.sv
src/table_driven_transducer.sv
dv/tb_top.sv
